### hw/rtl/tsm_pkg.sv
// Package: shared types, constants and codes for the tetrahedron stub matcher.
package tsm_pkg;

    localparam int NODES_DEF     = 1024;
    localparam int MAX_TETRA_DEF = 16;
    localparam int STUB_BITS_DEF = 16;
    localparam int NODE_W        = 10;
    localparam int REM_W         = 26;
    localparam int BT_W          = 17;
    localparam int CFG_W         = 16;
    localparam logic [15:0] MAX_BT_RESET = 16'd80;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_REPEAT  = 3'd1,
        ST_DUP     = 3'd2,
        ST_FULL    = 3'd3,
        ST_DONE    = 3'd4
    } t_status;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_PROPOSE = 1'b1
    } t_op;

    typedef enum logic {
        REG_ALLOW_BT = 1'b0,
        REG_MAX_BT   = 1'b1
    } t_reg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_LCLR, S_PDONE, S_WALK_RD, S_WALK, S_PICK_RD, S_PICK_WR,
        S_SCAN_RD, S_SCAN, S_CHECK, S_APPEND, S_UNDO_RD, S_UNDO_WR, S_FIN,
        S_RESP
    } t_state;

    typedef struct packed {
        logic [0:0]        opcode;
        logic [NODE_W-1:0] node_index;
        logic [15:0]       stub_count;
        logic [31:0]       rand_first;
        logic [31:0]       rand_second;
        logic [31:0]       rand_third;
        logic [31:0]       rand_fourth;
    } t_req;

    typedef struct packed {
        logic [2:0]        status;
        logic [NODE_W-1:0] pick_first;
        logic [NODE_W-1:0] pick_second;
        logic [NODE_W-1:0] pick_third;
        logic [NODE_W-1:0] pick_fourth;
        logic              done_res;
        logic [REM_W-1:0]  remaining;
        logic [BT_W-1:0]   backtracks;
    } t_rsp;

endpackage

### hw/rtl/tsm_list_mem.sv
// Tetrahedron list memory: one row of three node indexes per entry.
module tsm_list_mem #(
    parameter int AW = 14,
    parameter int DW = 30
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

### hw/rtl/tsm_node_mem.sv
// Node memory: free and used stub counts per node; the top level clears it after reset.
module tsm_node_mem #(
    parameter int AW = 10,
    parameter int DW = 21
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

### hw/rtl/tetrahedron_stub_matcher.sv
// Top level: sequencer around the node memory and the tetrahedron list memory.
// A request is taken when start is high and busy low; one result follows as a
// one-cycle o_valid strobe that the receiver cannot stall. After reset a clearing
// pass sweeps the node memory, one node a cycle, with busy high. A load zeroes the
// node's list rows one per cycle. A propose runs four cumulative walks over the
// node memory at one node per cycle, then scans up to MAX_TETRA list rows of the
// first node and either appends a list row to each of the four picked nodes or
// restores the four nodes when backtracking is allowed.
module tetrahedron_stub_matcher #(
    parameter int NODES     = tsm_pkg::NODES_DEF,
    parameter int MAX_TETRA = tsm_pkg::MAX_TETRA_DEF,
    parameter int STUB_BITS = tsm_pkg::STUB_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  tsm_pkg::t_req              i_req,
    output logic                       o_valid,
    output tsm_pkg::t_rsp              o_rsp,
    input  logic                       i_cfg_we,
    input  logic [0:0]                 i_cfg_idx,
    input  logic [tsm_pkg::CFG_W-1:0]  i_cfg_data
);
    localparam int NW  = tsm_pkg::NODE_W;
    localparam int AW  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CW  = $clog2(NODES + 1);
    localparam int TW  = (MAX_TETRA > 1) ? $clog2(MAX_TETRA) : 1;
    localparam int UW  = $clog2(MAX_TETRA + 2);
    localparam int DW  = STUB_BITS + UW;
    localparam int LW  = AW + TW;
    localparam int RW  = tsm_pkg::REM_W;
    localparam int SW  = RW + 1;
    localparam logic [UW-1:0] USAT = UW'(MAX_TETRA + 1);
    localparam logic [UW-1:0] UMAX = UW'(MAX_TETRA);

    tsm_pkg::t_state r_state, n_state;

    // configuration
    logic        r_allow_bt;
    logic [15:0] r_max_bt;

    logic [RW-1:0]            r_rem, n_rem;
    logic [tsm_pkg::BT_W-1:0] r_bt, n_bt;
    tsm_pkg::t_req            r_req, n_req;
    logic [CW-1:0]            r_cnt, n_cnt;
    logic [1:0]               r_k, n_k;
    logic [RW-1:0]            r_v, n_v;
    logic [SW-1:0]            r_cum, n_cum;
    logic [AW-1:0]            r_pick [4];
    logic [AW-1:0]            n_pick [4];
    logic [UW-1:0]            r_oldu [4];
    logic [UW-1:0]            n_oldu [4];
    logic [3:0]               r_took, n_took, r_inc, n_inc;
    logic [2:0]               r_stat, n_stat;
    tsm_pkg::t_rsp            r_rsp, n_rsp;
    logic                     r_valid, n_valid;
    logic [63:0]              r_prod, n_prod;
    logic                     r_prod_ok, n_prod_ok;

    // node memory
    logic          nm_we;
    logic [AW-1:0] nm_waddr, nm_raddr;
    logic [DW-1:0] nm_wdata, nm_rdata;
    logic [STUB_BITS-1:0] rd_free;
    logic [UW-1:0]        rd_used;
    // list memory
    logic          lm_we;
    logic [LW-1:0] lm_waddr, lm_raddr;
    logic [3*NW-1:0] lm_wdata, lm_rdata;

    tsm_node_mem #(.AW(AW), .DW(DW)) u_node (
        .i_clk(i_clk), .i_we(nm_we), .i_waddr(nm_waddr), .i_wdata(nm_wdata),
        .i_raddr(nm_raddr), .o_rdata(nm_rdata));
    tsm_list_mem #(.AW(LW), .DW(3*NW)) u_list (
        .i_clk(i_clk), .i_we(lm_we), .i_waddr(lm_waddr), .i_wdata(lm_wdata),
        .i_raddr(lm_raddr), .o_rdata(lm_rdata));

    assign rd_free = nm_rdata[DW-1:UW];
    assign rd_used = nm_rdata[UW-1:0];

    function automatic logic [3*NW-1:0] sort3(input logic [3*NW-1:0] t);
        logic [NW-1:0] a, b, c, s;
        begin
            a = t[3*NW-1:2*NW]; b = t[2*NW-1:NW]; c = t[NW-1:0];
            if (a > b) begin s = a; a = b; b = s; end
            if (b > c) begin s = b; b = c; c = s; end
            if (a > b) begin s = a; a = b; b = s; end
            sort3 = {a, b, c};
        end
    endfunction

    logic [15:0] limit_m1;
    logic        done_now;
    assign limit_m1 = r_allow_bt ? r_max_bt : 16'd0;
    assign done_now = (r_rem <= RW'(4)) || (r_bt > {1'b0, limit_m1});

    logic [31:0] rand_sel;
    always_comb begin
        case (r_k)
            2'd0:    rand_sel = r_req.rand_first;
            2'd1:    rand_sel = r_req.rand_second;
            2'd2:    rand_sel = r_req.rand_third;
            default: rand_sel = r_req.rand_fourth;
        endcase
    end

    logic [NW-1:0] pk [4];
    logic          repeat_hit, full_hit;
    logic [3*NW-1:0] want;
    always_comb begin
        for (int i = 0; i < 4; i++) pk[i] = NW'(r_pick[i]);
        repeat_hit = (pk[0] == pk[1]) || (pk[0] == pk[2]) || (pk[0] == pk[3]) ||
                     (pk[1] == pk[2]) || (pk[1] == pk[3]) || (pk[2] == pk[3]);
        full_hit = 1'b0;
        for (int i = 0; i < 4; i++) if (r_oldu[i] >= UMAX) full_hit = 1'b1;
        want = sort3({pk[1], pk[2], pk[3]});
    end

    logic [UW-1:0] scan_n;
    assign scan_n = (r_oldu[0] < UMAX) ? r_oldu[0] : UMAX;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_allow_bt <= 1'b1;
            r_max_bt   <= tsm_pkg::MAX_BT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tsm_pkg::REG_ALLOW_BT: r_allow_bt <= i_cfg_data[0];
                tsm_pkg::REG_MAX_BT:   r_max_bt   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsm_pkg::S_IDLE;
            r_rem   <= '0;
            r_bt    <= '0;
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_rem   <= n_rem;
            r_bt    <= n_bt;
            r_valid <= n_valid;
            r_cnt   <= n_cnt;
        end
        r_req <= n_req; r_k <= n_k; r_v <= n_v; r_cum <= n_cum;
        r_took <= n_took; r_inc <= n_inc; r_stat <= n_stat; r_rsp <= n_rsp;
        r_prod <= n_prod; r_prod_ok <= n_prod_ok;
        for (int i = 0; i < 4; i++) begin
            r_pick[i] <= n_pick[i];
            r_oldu[i] <= n_oldu[i];
        end
    end

    // reset clearing pass flag: r_cnt counts nodes while r_clr is set
    logic r_clr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_clr <= 1'b1;
        else if (r_clr && r_cnt == CW'(NODES - 1)) r_clr <= 1'b0;
    end

    always_comb begin
        n_state = r_state; n_rem = r_rem; n_bt = r_bt; n_req = r_req;
        n_cnt = r_cnt; n_k = r_k; n_v = r_v; n_cum = r_cum;
        n_took = r_took; n_inc = r_inc; n_stat = r_stat; n_rsp = r_rsp;
        n_valid = 1'b0; n_prod = r_prod; n_prod_ok = 1'b0;
        for (int i = 0; i < 4; i++) begin
            n_pick[i] = r_pick[i];
            n_oldu[i] = r_oldu[i];
        end
        nm_we = 1'b0; nm_waddr = '0; nm_wdata = '0; nm_raddr = '0;
        lm_we = 1'b0; lm_waddr = '0; lm_wdata = '0; lm_raddr = '0;
        busy = (r_state != tsm_pkg::S_IDLE) || r_clr;

        case (r_state)
            tsm_pkg::S_IDLE: begin
                if (r_clr) begin
                    nm_we = 1'b1; nm_waddr = AW'(r_cnt);
                    n_cnt = (r_cnt == CW'(NODES - 1)) ? '0 : r_cnt + 1'b1;
                end else if (start) begin
                    n_req = i_req;
                    n_stat = tsm_pkg::ST_OK;
                    for (int i = 0; i < 4; i++) n_pick[i] = '0;
                    n_cnt = '0; n_k = '0;
                    if (i_req.opcode == tsm_pkg::OP_LOAD) begin
                        if (32'(i_req.node_index) < 32'(NODES)) begin
                            nm_raddr = AW'(i_req.node_index);
                            n_state = tsm_pkg::S_LCLR;
                        end else begin
                            n_state = tsm_pkg::S_FIN;
                        end
                    end else if (done_now) begin
                        n_stat = tsm_pkg::ST_DONE;
                        n_state = tsm_pkg::S_FIN;
                    end else begin
                        n_state = tsm_pkg::S_WALK_RD;
                    end
                end
            end
            tsm_pkg::S_LCLR: begin
                // first cycle: node row read is valid; rows of its list are zeroed
                if (r_cnt == '0) begin
                    n_rem = RW'(r_rem - RW'(rd_free)
                              + RW'(r_req.stub_count[STUB_BITS-1:0]));
                    nm_we = 1'b1; nm_waddr = AW'(r_req.node_index);
                    nm_wdata = {r_req.stub_count[STUB_BITS-1:0], {UW{1'b0}}};
                    n_bt = '0;
                end
                lm_we = 1'b1;
                lm_waddr = {AW'(r_req.node_index), TW'(r_cnt)};
                if (r_cnt == CW'(MAX_TETRA - 1)) n_state = tsm_pkg::S_FIN;
                else n_cnt = r_cnt + 1'b1;
            end
            tsm_pkg::S_WALK_RD: begin
                // product registered; walk starts next cycle at node 0
                n_prod = 64'(rand_sel) * 64'(r_rem);
                n_prod_ok = 1'b1;
                nm_raddr = '0;
                n_cum = '0; n_cnt = '0;
                n_state = tsm_pkg::S_WALK;
            end
            tsm_pkg::S_WALK: begin
                if (r_prod_ok) n_v = RW'(r_prod[63:32]);
                begin
                    logic [SW-1:0] c;
                    logic [RW-1:0] v;
                    v = r_prod_ok ? RW'(r_prod[63:32]) : r_v;
                    c = r_cum + SW'(rd_free);
                    n_cum = c;
                    if (SW'(v) < c || r_cnt == CW'(NODES - 1)) begin
                        n_pick[r_k] = AW'(r_cnt);
                        nm_raddr = AW'(r_cnt);
                        n_state = tsm_pkg::S_PICK_RD;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                        nm_raddr = AW'(r_cnt + 1'b1);
                    end
                end
            end
            tsm_pkg::S_PICK_RD: begin
                nm_raddr = r_pick[r_k];
                n_state = tsm_pkg::S_PICK_WR;
            end
            tsm_pkg::S_PICK_WR: begin
                begin
                    logic [STUB_BITS-1:0] f;
                    logic [UW-1:0] u;
                    f = rd_free; u = rd_used;
                    n_oldu[r_k] = rd_used;
                    n_took[r_k] = 1'b0; n_inc[r_k] = 1'b0;
                    if (f != '0 && r_rem != '0) begin
                        f = f - 1'b1; n_rem = r_rem - 1'b1; n_took[r_k] = 1'b1;
                    end
                    if (u < USAT) begin
                        u = u + 1'b1; n_inc[r_k] = 1'b1;
                    end
                    nm_we = 1'b1; nm_waddr = r_pick[r_k]; nm_wdata = {f, u};
                end
                if (r_k == 2'd3) begin
                    n_state = tsm_pkg::S_SCAN_RD;
                end else begin
                    n_k = r_k + 1'b1;
                    n_state = tsm_pkg::S_WALK_RD;
                end
                n_cnt = '0;
            end
            tsm_pkg::S_SCAN_RD: begin
                if (repeat_hit) begin
                    n_stat = tsm_pkg::ST_REPEAT; n_state = tsm_pkg::S_CHECK;
                end else if (UW'(r_cnt) >= scan_n) begin
                    n_state = tsm_pkg::S_CHECK;
                end else begin
                    lm_raddr = {r_pick[0], TW'(r_cnt)};
                    n_state = tsm_pkg::S_SCAN;
                end
            end
            tsm_pkg::S_SCAN: begin
                if (sort3(lm_rdata) == want) begin
                    n_stat = tsm_pkg::ST_DUP; n_state = tsm_pkg::S_CHECK;
                end else begin
                    n_cnt = r_cnt + 1'b1; n_state = tsm_pkg::S_SCAN_RD;
                end
            end
            tsm_pkg::S_CHECK: begin
                n_k = '0;
                if (r_stat == tsm_pkg::ST_OK && full_hit) n_stat = tsm_pkg::ST_FULL;
                if (r_stat == tsm_pkg::ST_OK && !full_hit) begin
                    n_state = tsm_pkg::S_APPEND;
                end else begin
                    n_bt = r_bt + 1'b1;
                    n_state = r_allow_bt ? tsm_pkg::S_UNDO_RD : tsm_pkg::S_FIN;
                end
            end
            tsm_pkg::S_APPEND: begin
                lm_we = 1'b1;
                lm_waddr = {r_pick[r_k], TW'(r_oldu[r_k])};
                case (r_k)
                    2'd0:    lm_wdata = {pk[1], pk[2], pk[3]};
                    2'd1:    lm_wdata = {pk[0], pk[2], pk[3]};
                    2'd2:    lm_wdata = {pk[0], pk[1], pk[3]};
                    default: lm_wdata = {pk[0], pk[1], pk[2]};
                endcase
                n_k = r_k + 1'b1;
                if (r_k == 2'd3) n_state = tsm_pkg::S_FIN;
            end
            tsm_pkg::S_UNDO_RD: begin
                nm_raddr = r_pick[r_k];
                n_state = tsm_pkg::S_UNDO_WR;
            end
            tsm_pkg::S_UNDO_WR: begin
                begin
                    logic [STUB_BITS-1:0] f;
                    logic [UW-1:0] u;
                    logic [RW-1:0] rm;
                    f = rd_free; u = rd_used; rm = r_rem;
                    if (r_took[r_k]) begin f = f + 1'b1; rm = rm + 1'b1; end
                    if (r_inc[r_k] && u != '0) u = u - 1'b1;
                    n_rem = rm;
                    nm_we = 1'b1; nm_waddr = r_pick[r_k]; nm_wdata = {f, u};
                end
                n_k = r_k + 1'b1;
                n_state = (r_k == 2'd3) ? tsm_pkg::S_FIN : tsm_pkg::S_UNDO_RD;
            end
            tsm_pkg::S_FIN: begin
                n_rsp.status = r_stat;
                n_rsp.pick_first  = pk[0];
                n_rsp.pick_second = pk[1];
                n_rsp.pick_third  = pk[2];
                n_rsp.pick_fourth = pk[3];
                n_rsp.done_res = done_now;
                n_rsp.remaining = r_rem;
                n_rsp.backtracks = r_bt;
                n_valid = 1'b1;
                n_state = tsm_pkg::S_RESP;
            end
            tsm_pkg::S_RESP: begin
                n_state = tsm_pkg::S_IDLE;
            end
            default: n_state = tsm_pkg::S_IDLE;
        endcase
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;
endmodule

### hw/rtl/tsm_checker.sv
// Port-level checker for the tetrahedron stub matcher, bound to the top level.
module tsm_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input logic          o_valid,
    input tsm_pkg::t_rsp o_rsp
);
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("busy not raised after request");
    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rsp.status <= tsm_pkg::ST_DONE)) else $error("bad status");
    a_done_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rsp.status == tsm_pkg::ST_DONE) |-> o_rsp.done_res)
        else $error("done status without done flag");
endmodule

bind tetrahedron_stub_matcher tsm_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_rsp(o_rsp));
